/* rtl/core/ihex_pkg.sv */
// Shared types, codes and helpers for the Intel HEX record loader.
// Used by ihex_decoder and intel_hex_record_loader_core; no dependencies.
package ihex_pkg;

	// Address width; all load addresses wrap to this many bits
	localparam int ADDR_WIDTH = 32;
	localparam logic [31:0] ADDR_MASK = 32'((64'd1 << ADDR_WIDTH) - 64'd1);

	// Register reset values
	localparam logic [31:0] RAM_BASE_RESET    = 32'h0200_0000;
	localparam logic [31:0] FLUSH_LIMIT_RESET = 32'h021F_FFFF;

	// Register indexes (paddr[2])
	localparam logic REG_RAM_BASE    = 1'b0;
	localparam logic REG_FLUSH_LIMIT = 1'b1;

	// Characters and special bytes
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] EOF_BYTE = 8'hFF;

	// Record types
	localparam logic [7:0] RT_DATA   = 8'h00;
	localparam logic [7:0] RT_EOF    = 8'h01;
	localparam logic [7:0] RT_EXT    = 8'h04;
	localparam logic [7:0] RT_START  = 8'h05;
	localparam logic [7:0] RT_FLUSH  = 8'h77;
	localparam logic [7:0] RT_EEPROM = 8'h88;

	// Event codes
	localparam logic [2:0] EV_NONE    = 3'd0;
	localparam logic [2:0] EV_OK      = 3'd1;
	localparam logic [2:0] EV_SUM_ERR = 3'd2;
	localparam logic [2:0] EV_BAD_TYPE = 3'd3;
	localparam logic [2:0] EV_EOF     = 3'd4;
	localparam logic [2:0] EV_EEPROM  = 3'd5;
	localparam logic [2:0] EV_FLUSH   = 3'd6;

	// Record parser phases, one-hot
	typedef enum logic [11:0] {
		PH_WAIT      = 12'b0000_0000_0001,
		PH_LEN       = 12'b0000_0000_0010,
		PH_AHI       = 12'b0000_0000_0100,
		PH_ALO       = 12'b0000_0000_1000,
		PH_TYPE      = 12'b0000_0001_0000,
		PH_DATA      = 12'b0000_0010_0000,
		PH_DSUM      = 12'b0000_0100_0000,
		PH_EOFB      = 12'b0000_1000_0000,
		PH_EXT       = 12'b0001_0000_0000,
		PH_EXTSUM    = 12'b0010_0000_0000,
		PH_START     = 12'b0100_0000_0000,
		PH_STARTSUM  = 12'b1000_0000_0000
	} phase_t;

	// One result transaction
	typedef struct packed {
		logic        mem_write;
		logic [31:0] mem_addr;
		logic [7:0]  mem_data;
		logic [2:0]  event_res;
		logic        eeprom_write_request;
		logic [31:0] highest_address;
		logic [31:0] entry_address;
		logic        done_res;
	} res_t;

	// Hex digit value; anything that is not a hex digit counts as zero
	function automatic logic [3:0] hex_digit(input logic [7:0] c);
		logic [7:0] t;
		t = 8'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			t = c - 8'h30;
		end else if (c >= 8'h41 && c <= 8'h46) begin
			t = c - 8'h37;
		end else if (c >= 8'h61 && c <= 8'h66) begin
			t = c - 8'h57;
		end
		return t[3:0];
	endfunction

endpackage

/* rtl/core/ihex_decoder.sv */
// Intel HEX record parser: record state and the per-character update.
// Depends on ihex_pkg for phase codes, record types, event codes and res_t.
module ihex_decoder (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic [7:0]        ch,
	input  logic              cfg_base_wr,
	input  logic [31:0]       cfg_base,
	input  logic [31:0]       flush_limit,
	output ihex_pkg::res_t    result
);

	ihex_pkg::phase_t phase_q, phase_d;
	logic [3:0]  hi_q, hi_d;
	logic        pend_q, pend_d;
	logic [7:0]  left_q, left_d;
	logic [1:0]  fidx_q, fidx_d;
	logic [7:0]  sum_q, sum_d;
	logic [31:0] wp_q, wp_d;
	logic [31:0] base_q, base_d;
	logic [31:0] word_q, word_d;
	logic [31:0] top_q, top_d;
	logic [31:0] start_q, start_d;
	logic        eeprom_q, eeprom_d;
	logic        fin_q, fin_d;

	logic [3:0]  digit;
	logic [7:0]  b;
	logic [7:0]  sum_new;
	logic [31:0] wp_new;
	logic [7:0]  left_new;
	logic [2:0]  sum_ev;

	assign digit    = ihex_pkg::hex_digit(ch);
	assign b        = {hi_q, digit};
	assign sum_new  = sum_q + b;
	assign left_new = left_q - 8'd1;
	assign sum_ev   = (sum_new != 8'd0) ? ihex_pkg::EV_SUM_ERR : ihex_pkg::EV_OK;

	// Compute next state and the result for one character
	always_comb begin
		phase_d  = phase_q;
		hi_d     = hi_q;
		pend_d   = pend_q;
		left_d   = left_q;
		fidx_d   = fidx_q;
		sum_d    = sum_q;
		wp_d     = wp_q;
		base_d   = base_q;
		word_d   = word_q;
		top_d    = top_q;
		start_d  = start_q;
		eeprom_d = eeprom_q;
		fin_d    = fin_q;
		wp_new   = wp_q;
		result   = '0;

		if (fin_q) begin
			// ignore everything after end of file
		end else if (phase_q == ihex_pkg::PH_WAIT) begin
			if (ch == ihex_pkg::CH_COLON) begin
				phase_d = ihex_pkg::PH_LEN;
				pend_d  = 1'b0;
			end
		end else if (!pend_q) begin
			hi_d   = digit;
			pend_d = 1'b1;
		end else begin
			pend_d = 1'b0;
			sum_d  = sum_new;
			unique case (phase_q)
				ihex_pkg::PH_LEN: begin
					left_d  = b;
					sum_d   = b;
					phase_d = ihex_pkg::PH_AHI;
				end
				ihex_pkg::PH_AHI: begin
					word_d  = {16'd0, b, 8'd0};
					phase_d = ihex_pkg::PH_ALO;
				end
				ihex_pkg::PH_ALO: begin
					word_d  = word_q | {24'd0, b};
					phase_d = ihex_pkg::PH_TYPE;
				end
				ihex_pkg::PH_TYPE: begin
					fidx_d = 2'd0;
					priority if (b == ihex_pkg::RT_DATA) begin
						wp_new = (base_q + word_q) & ihex_pkg::ADDR_MASK;
						wp_d   = wp_new;
						if (left_q == 8'd0) begin
							if (top_q < wp_new) top_d = wp_new;
							phase_d = ihex_pkg::PH_DSUM;
						end else begin
							phase_d = ihex_pkg::PH_DATA;
						end
					end else if (b == ihex_pkg::RT_EOF) begin
						phase_d = ihex_pkg::PH_EOFB;
					end else if (b == ihex_pkg::RT_EXT) begin
						word_d  = 32'd0;
						phase_d = ihex_pkg::PH_EXT;
					end else if (b == ihex_pkg::RT_START) begin
						word_d  = 32'd0;
						phase_d = ihex_pkg::PH_START;
					end else if (b == ihex_pkg::RT_FLUSH) begin
						top_d            = flush_limit & ihex_pkg::ADDR_MASK;
						result.event_res = ihex_pkg::EV_FLUSH;
						phase_d          = ihex_pkg::PH_WAIT;
					end else if (b == ihex_pkg::RT_EEPROM) begin
						eeprom_d         = 1'b1;
						result.event_res = ihex_pkg::EV_EEPROM;
						phase_d          = ihex_pkg::PH_WAIT;
					end else begin
						eeprom_d         = 1'b0;
						result.event_res = ihex_pkg::EV_BAD_TYPE;
						phase_d          = ihex_pkg::PH_WAIT;
					end
				end
				ihex_pkg::PH_DATA: begin
					result.mem_write = 1'b1;
					result.mem_addr  = wp_q;
					result.mem_data  = b;
					wp_new = (wp_q + 32'd1) & ihex_pkg::ADDR_MASK;
					wp_d   = wp_new;
					left_d = left_new;
					if (left_new == 8'd0) begin
						if (top_q < wp_new) top_d = wp_new;
						phase_d = ihex_pkg::PH_DSUM;
					end
				end
				ihex_pkg::PH_DSUM: begin
					result.event_res = sum_ev;
					if (sum_new != 8'd0) eeprom_d = 1'b0;
					phase_d = ihex_pkg::PH_WAIT;
				end
				ihex_pkg::PH_EOFB: begin
					if (b == ihex_pkg::EOF_BYTE) begin
						fin_d                       = 1'b1;
						result.event_res            = ihex_pkg::EV_EOF;
						result.eeprom_write_request = eeprom_q;
					end
					phase_d = ihex_pkg::PH_WAIT;
				end
				ihex_pkg::PH_EXT: begin
					if (fidx_q == 2'd0) begin
						word_d = {b, 24'd0};
						fidx_d = 2'd1;
					end else begin
						word_d  = word_q | {8'd0, b, 16'd0};
						phase_d = ihex_pkg::PH_EXTSUM;
					end
				end
				ihex_pkg::PH_EXTSUM: begin
					base_d           = word_q & ihex_pkg::ADDR_MASK;
					result.event_res = sum_ev;
					if (sum_new != 8'd0) eeprom_d = 1'b0;
					phase_d = ihex_pkg::PH_WAIT;
				end
				ihex_pkg::PH_START: begin
					word_d = {word_q[23:0], b};
					if (fidx_q == 2'd3) phase_d = ihex_pkg::PH_STARTSUM;
					fidx_d = fidx_q + 2'd1;
				end
				ihex_pkg::PH_STARTSUM: begin
					start_d          = word_q & ihex_pkg::ADDR_MASK;
					result.event_res = sum_ev;
					if (sum_new != 8'd0) eeprom_d = 1'b0;
					phase_d = ihex_pkg::PH_WAIT;
				end
				default: begin
					phase_d = ihex_pkg::PH_WAIT;
				end
			endcase
		end

		result.highest_address = top_d;
		result.entry_address   = start_d;
		result.done_res        = fin_d;
	end

	// Hold record state; advance on each character, load base on register write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= ihex_pkg::PH_WAIT;
			hi_q     <= '0;
			pend_q   <= 1'b0;
			left_q   <= '0;
			fidx_q   <= '0;
			sum_q    <= '0;
			wp_q     <= '0;
			base_q   <= ihex_pkg::RAM_BASE_RESET & ihex_pkg::ADDR_MASK;
			word_q   <= '0;
			top_q    <= '0;
			start_q  <= ihex_pkg::RAM_BASE_RESET & ihex_pkg::ADDR_MASK;
			eeprom_q <= 1'b0;
			fin_q    <= 1'b0;
		end else if (cfg_base_wr) begin
			base_q  <= cfg_base & ihex_pkg::ADDR_MASK;
			start_q <= cfg_base & ihex_pkg::ADDR_MASK;
		end else if (step) begin
			phase_q  <= phase_d;
			hi_q     <= hi_d;
			pend_q   <= pend_d;
			left_q   <= left_d;
			fidx_q   <= fidx_d;
			sum_q    <= sum_d;
			wp_q     <= wp_d;
			base_q   <= base_d;
			word_q   <= word_d;
			top_q    <= top_d;
			start_q  <= start_d;
			eeprom_q <= eeprom_d;
			fin_q    <= fin_d;
		end
	end

endmodule

/* rtl/core/intel_hex_record_loader_core.sv */
// Intel HEX record loader top level: APB registers, input and result stages.
// Depends on ihex_pkg and ihex_decoder.
//
// Usage:
//   Feed one received character per transaction on ch / ch_valid / ch_stall.
//   Every accepted character yields exactly one result transaction on
//   res_valid / res_stall carrying the memory write (mem_write, mem_addr,
//   mem_data), the record event and the loader status.
//   Each accepted character is held in the input stage, decoded, and its
//   result is loaded into the result register before res_valid shows it.
//   Throughput: one character per cycle while res_stall is low; the record
//   state is updated in a single pass between input and result stages.
//   Stalls: while res_stall holds a result, one more character can sit in
//   the input stage; after that ch_stall rises until the result is taken.
//   Reset: clears both stages and the parser; ram_base and
//   flush_limit_address return to their defaults, base and entry address
//   to ram_base.
//   Registers (APB, write only while no transaction is in flight):
//   0x0 ram_base (also reloads base and entry address), 0x4
//   flush_limit_address. pready is always high.
module intel_hex_record_loader_core (
	input  logic        clk,
	input  logic        arst_n,
	// APB configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// Character channel
	input  logic        ch_valid,
	output logic        ch_stall,
	input  logic [7:0]  ch,
	// Result channel
	output logic        res_valid,
	input  logic        res_stall,
	output logic        mem_write,
	output logic [31:0] mem_addr,
	output logic [7:0]  mem_data,
	output logic [2:0]  event_res,
	output logic        eeprom_write_request,
	output logic [31:0] highest_address,
	output logic [31:0] entry_address,
	output logic        done_res
);

	logic [31:0]    ram_base_q;
	logic [31:0]    flush_limit_q;
	logic           cfg_wr;
	logic           valid_s1;
	logic [7:0]     ch_s1;
	logic           ch_accept;
	logic           step;
	logic           res_valid_q;
	ihex_pkg::res_t res_q;
	ihex_pkg::res_t res_next;

	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ram_base_q    <= ihex_pkg::RAM_BASE_RESET;
			flush_limit_q <= ihex_pkg::FLUSH_LIMIT_RESET;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				ihex_pkg::REG_RAM_BASE:    ram_base_q    <= pwdata;
				ihex_pkg::REG_FLUSH_LIMIT: flush_limit_q <= pwdata;
				default:                   ram_base_q    <= ram_base_q;
			endcase
		end
	end

	// Read back configuration registers
	always_comb begin
		unique case (paddr[2])
			ihex_pkg::REG_RAM_BASE:    prdata = ram_base_q;
			ihex_pkg::REG_FLUSH_LIMIT: prdata = flush_limit_q;
			default:                   prdata = '0;
		endcase
	end

	// Advance the input stage whenever the result register is free or drains
	assign step      = valid_s1 & (~res_valid_q | ~res_stall);
	assign ch_stall  = valid_s1 & ~step;
	assign ch_accept = ch_valid & ~ch_stall;

	// Hold the accepted character in the input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ch_accept) begin
			valid_s1 <= 1'b1;
		end else if (step) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ch_accept) ch_s1 <= ch;
	end

	ihex_decoder u_decoder (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (step),
		.ch          (ch_s1),
		.cfg_base_wr (cfg_wr & (paddr[2] == ihex_pkg::REG_RAM_BASE)),
		.cfg_base    (pwdata),
		.flush_limit (flush_limit_q),
		.result      (res_next)
	);

	// Hold the result transaction until it is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (step) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step) res_q <= res_next;
	end

	assign res_valid            = res_valid_q;
	assign mem_write            = res_q.mem_write;
	assign mem_addr             = res_q.mem_addr;
	assign mem_data             = res_q.mem_data;
	assign event_res            = res_q.event_res;
	assign eeprom_write_request = res_q.eeprom_write_request;
	assign highest_address      = res_q.highest_address;
	assign entry_address        = res_q.entry_address;
	assign done_res             = res_q.done_res;

endmodule
